@@ rtl/ude_pkg.sv @@
// Shared widths, constants, stage payload types and the month table for the epoch converter.
package ude_pkg;

  // Field widths
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int MDAY_W  = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 10;
  localparam int EPOCH_W = 35;
  localparam int YDAY_W  = 9;
  localparam int WDAY_W  = 3;

  // Internal widths: day count since epoch, seconds within a day, century count
  localparam int DAYS_W = 19;
  localparam int TOD_W  = 17;
  localparam int CENT_W = 4;
  localparam int CORR_W = 5;

  // Calendar constants
  localparam int EPOCH_YEAR_OFS  = 70;
  localparam int DAYS_PER_YEAR   = 365;
  localparam int FIRST_CENT_YRS  = 131;
  localparam int YEARS_PER_CENT  = 100;
  localparam int MAX_CENT        = 8;
  localparam int MAX_CENT_YEAR   = 10;
  localparam int SECS_PER_DAY    = 86400;
  localparam int SECS_PER_HOUR   = 3600;
  localparam int SECS_PER_MIN    = 60;
  localparam int EPOCH_WEEKDAY   = 4;
  localparam int DAYS_PER_WEEK   = 7;
  localparam int LAST_MONTH      = 11;
  localparam int FEB_MONTH       = 1;

  // Century years (since 1900) that are multiples of 400 in the calendar
  localparam int Q400_YEAR_A = 100;
  localparam int Q400_YEAR_B = 500;
  localparam int Q400_YEAR_C = 900;

  // Days before the start of each month in a common year
  function automatic logic [YDAY_W-1:0] days_before_month(input logic [MON_W-1:0] mon);
    logic [YDAY_W-1:0] d;
    unique case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

  // Stage 1: year day count before correction, century count, day of year, time of day
  typedef struct packed {
    logic              pre_epoch;
    logic [DAYS_W-1:0] days_raw;
    logic              has_corr;
    logic [CENT_W-1:0] cent;
    logic [YDAY_W-1:0] yday;
    logic [TOD_W-1:0]  tod;
  } s1_t;

  // Stage 2: full day count since epoch
  typedef struct packed {
    logic              pre_epoch;
    logic [DAYS_W-1:0] days;
    logic [YDAY_W-1:0] yday;
    logic [TOD_W-1:0]  tod;
  } s2_t;

  // Stage 3: day seconds product and weekday
  typedef struct packed {
    logic               pre_epoch;
    logic [EPOCH_W-1:0] day_secs;
    logic [YDAY_W-1:0]  yday;
    logic [TOD_W-1:0]   tod;
    logic [WDAY_W-1:0]  wday;
  } s3_t;

endpackage

@@ rtl/ude_in_if.sv @@
// Input channel: broken-down UTC date and time with valid/ready handshake.
interface ude_in_if;
  import ude_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEC_W-1:0]  second;
  logic [MIN_W-1:0]  minute;
  logic [HOUR_W-1:0] hour;
  logic [MDAY_W-1:0] day_of_month;
  logic [MON_W-1:0]  month;
  logic [YEAR_W-1:0] years_since_1900;

  modport source (output valid, second, minute, hour, day_of_month, month,
                  years_since_1900, input ready);
  modport sink   (input valid, second, minute, hour, day_of_month, month,
                  years_since_1900, output ready);
endinterface

@@ rtl/ude_out_if.sv @@
// Result channel: seconds since epoch, day of year, weekday and error flag.
interface ude_out_if;
  import ude_pkg::*;

  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;
  logic [YDAY_W-1:0]  day_of_year;
  logic [WDAY_W-1:0]  weekday;
  logic               before_epoch;

  modport source (output valid, epoch_seconds, day_of_year, weekday, before_epoch,
                  input ready);
  modport sink   (input valid, epoch_seconds, day_of_year, weekday, before_epoch,
                  output ready);
endinterface

@@ rtl/utc_date_to_epoch_seconds.sv @@
// Top level: four-stage pipeline converting a UTC date and time to seconds since 1970.
//
// The block takes one beat per cycle unless the pipeline is full behind a stalled result,
// and passes each beat through stage registers s1_r, s2_r and s3_r to the result registers,
// in order, one result beat for each input beat. Stage 1 forms the whole-year day count, the
// Gregorian century count, the day of year and the seconds within the day; stage 2
// applies the century correction and adds the day of year; stage 3 multiplies the day
// count by 86400 and reduces it mod 7 for the weekday; stage 4 adds the time of day and
// holds the result beat. Each stage has its own valid bit and takes a new beat whenever
// it is empty or its successor moves, so bubbles close up under back-pressure and a
// stalled result never blocks accepting input until all four stages are full. Years
// before 1970 give before_epoch set and all other result fields zero.
module utc_date_to_epoch_seconds (
  input logic clk,
  input logic rst_n,
  ude_in_if.sink    in_ch,
  ude_out_if.source out_ch
);
  import ude_pkg::*;

  // Stage valid bits and per-stage ready
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;

  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [YDAY_W-1:0]  yday_r;
  logic [WDAY_W-1:0]  wday_r;
  logic               before_r;

  // Ready propagates back from the output
  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  // Stage 1: year days, century count, day of year, time of day
  logic [YEAR_W-1:0] yrs;
  logic [YEAR_W:0]   yrs_p1;
  logic [MON_W-1:0]  mon_sat;
  logic [MDAY_W-1:0] mday_f;
  logic              cent_year;
  logic              q400_year;
  logic              leap;
  logic [CENT_W-1:0] cent_cnt;

  always_comb begin
    yrs    = in_ch.years_since_1900 - YEAR_W'(EPOCH_YEAR_OFS);
    yrs_p1 = {1'b0, yrs} + (YEAR_W+1)'(1);

    // Count the skipped century years already passed
    cent_cnt = '0;
    for (int k = 1; k <= MAX_CENT; k++) begin
      if (yrs >= YEAR_W'(FIRST_CENT_YRS + YEARS_PER_CENT * k))
        cent_cnt = cent_cnt + CENT_W'(1);
    end

    // Leap year test on the calendar year
    cent_year = 1'b0;
    for (int k = 1; k <= MAX_CENT_YEAR; k++) begin
      if (in_ch.years_since_1900 == YEAR_W'(YEARS_PER_CENT * k))
        cent_year = 1'b1;
    end
    q400_year = (in_ch.years_since_1900 == YEAR_W'(Q400_YEAR_A)) ||
                (in_ch.years_since_1900 == YEAR_W'(Q400_YEAR_B)) ||
                (in_ch.years_since_1900 == YEAR_W'(Q400_YEAR_C));
    leap = (in_ch.years_since_1900[1:0] == 2'b00) && (!cent_year || q400_year);

    // Saturate month, clamp day zero to one
    mon_sat = (in_ch.month > MON_W'(LAST_MONTH)) ? MON_W'(LAST_MONTH) : in_ch.month;
    mday_f  = (in_ch.day_of_month == '0) ? MDAY_W'(1) : in_ch.day_of_month;

    s1_nxt.pre_epoch = in_ch.years_since_1900 < YEAR_W'(EPOCH_YEAR_OFS);
    s1_nxt.days_raw  = DAYS_W'(yrs) * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(yrs_p1[YEAR_W:2]);
    s1_nxt.has_corr  = yrs >= YEAR_W'(FIRST_CENT_YRS);
    s1_nxt.cent      = cent_cnt;
    s1_nxt.yday      = days_before_month(mon_sat) + YDAY_W'(mday_f) - YDAY_W'(1) +
                       YDAY_W'((mon_sat > MON_W'(FEB_MONTH)) && leap);
    s1_nxt.tod       = TOD_W'(in_ch.hour) * TOD_W'(SECS_PER_HOUR) +
                       TOD_W'(in_ch.minute) * TOD_W'(SECS_PER_MIN) +
                       TOD_W'(in_ch.second);
  end

  // Stage 2: apply century correction and add day of year
  logic [CORR_W-1:0] corr;
  logic [1:0]        cent_lo;

  always_comb begin
    cent_lo = (s1_r.cent[1:0] == 2'd3) ? 2'd2 : s1_r.cent[1:0];
    corr    = s1_r.has_corr ?
              CORR_W'(s1_r.cent[CENT_W-1:2]) * CORR_W'(3) + CORR_W'(1) + CORR_W'(cent_lo) :
              '0;
    s2_nxt.pre_epoch = s1_r.pre_epoch;
    s2_nxt.days      = s1_r.days_raw - DAYS_W'(corr) + DAYS_W'(s1_r.yday);
    s2_nxt.yday      = s1_r.yday;
    s2_nxt.tod       = s1_r.tod;
  end

  // Stage 3: day seconds and weekday by octal digit folding (8 is 1 mod 7)
  logic [20:0] wv;
  logic [5:0]  wsum;
  logic [3:0]  wsum2;

  always_comb begin
    wv   = 21'(s2_r.days) + 21'(EPOCH_WEEKDAY);
    wsum = '0;
    for (int k = 0; k < 7; k++) begin
      wsum = wsum + 6'(wv[3*k +: 3]);
    end
    wsum2 = 4'(wsum[2:0]) + 4'(wsum[5:3]);
    s3_nxt.wday = (wsum2 >= 4'(DAYS_PER_WEEK)) ? WDAY_W'(wsum2 - 4'(DAYS_PER_WEEK))
                                               : WDAY_W'(wsum2);
    s3_nxt.pre_epoch = s2_r.pre_epoch;
    s3_nxt.day_secs  = EPOCH_W'(s2_r.days) * EPOCH_W'(SECS_PER_DAY);
    s3_nxt.yday      = s2_r.yday;
    s3_nxt.tod       = s2_r.tod;
  end

  // Stage 4: add time of day, zero the result before the epoch
  assign epoch_nxt = s3_r.pre_epoch ? '0 : s3_r.day_secs + EPOCH_W'(s3_r.tod);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Payload registers advance with their stage
  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r) s2_r <= s2_nxt;
    if (rdy3 && v2_r) s3_r <= s3_nxt;
    if (rdy4 && v3_r) begin
      epoch_r  <= epoch_nxt;
      yday_r   <= s3_r.pre_epoch ? '0 : s3_r.yday;
      wday_r   <= s3_r.pre_epoch ? '0 : s3_r.wday;
      before_r <= s3_r.pre_epoch;
    end
  end

  assign out_ch.valid         = v4_r;
  assign out_ch.epoch_seconds = epoch_r;
  assign out_ch.day_of_year   = yday_r;
  assign out_ch.weekday       = wday_r;
  assign out_ch.before_epoch  = before_r;

endmodule

@@ rtl/ude_checker.sv @@
// Port-level checker for the epoch converter and its bind to the top level.
module ude_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ude_pkg::EPOCH_W-1:0] out_epoch_seconds,
  input logic [ude_pkg::YDAY_W-1:0]  out_day_of_year,
  input logic [ude_pkg::WDAY_W-1:0]  out_weekday,
  input logic                  out_before_epoch
);
  import ude_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // Input back-pressure only comes from a stalled result beat
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |-> (out_valid && !out_ready))
    else $error("input stalled while result side is free");

  // A pending result beat stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  // Pre-epoch results carry all-zero fields
  a_before_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_before_epoch) |->
      (out_epoch_seconds == '0 && out_day_of_year == '0 && out_weekday == '0))
    else $error("pre-epoch result with nonzero fields");

  // Weekday and day of year stay in range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weekday < WDAY_W'(DAYS_PER_WEEK) &&
                   out_day_of_year <= YDAY_W'(DAYS_PER_YEAR)))
    else $error("weekday or day of year out of range");

endmodule

bind utc_date_to_epoch_seconds ude_checker u_ude_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_epoch_seconds (out_ch.epoch_seconds),
  .out_day_of_year   (out_ch.day_of_year),
  .out_weekday       (out_ch.weekday),
  .out_before_epoch  (out_ch.before_epoch)
);
